// ===== hw/rtl/ats_pkg.sv =====
package ats_pkg;

	// Configuration register indexes.
	typedef enum logic {
		REG_DRIVE_GAIN = 1'b0,
		REG_WET_MIX    = 1'b1
	} cfg_reg_t;

	localparam int CFG_W = 16;

	// Shared multiplier operand widths (signed).
	localparam int MUL_AW = 35;
	localparam int MUL_BW = 26;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam int LUT_STEP_BITS = 22;
	localparam logic signed [31:0] LN2_Q24 = 32'sd11629080;
	localparam logic signed [32:0] TINY_Q24 = 33'sd17;
	localparam logic signed [MUL_BW-1:0] BLOCK_COEF_Q24 = 26'sd16726884;
	localparam logic [15:0] MIX_FULL = 16'd32768;
	localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

	localparam logic signed [31:0] TANH_TAB [33] = '{
		32'sd0, 32'sd4109053, 32'sd7753039, 32'sd10656031, 32'sd12777430, 32'sd14231838,
		32'sd15185868, 32'sd15793661, 32'sd16173699, 32'sd16408555, 32'sd16552641,
		32'sd16640645, 32'sd16694249, 32'sd16726845, 32'sd16746646, 32'sd16758668,
		32'sd16765964, 32'sd16770390, 32'sd16773076, 32'sd16774705, 32'sd16775693,
		32'sd16776292, 32'sd16776656, 32'sd16776876, 32'sd16777010, 32'sd16777091,
		32'sd16777140, 32'sd16777170, 32'sd16777188, 32'sd16777199, 32'sd16777206,
		32'sd16777210, 32'sd16777212
	};

	localparam logic signed [31:0] LOGCOSH_TAB [33] = '{
		32'sd0, 32'sd518916, 32'sd2015187, 32'sd4332986, 32'sd7277635, 32'sd10665990,
		32'sd14351905, 32'sd18230177, 32'sd22229857, 32'sd26305006, 32'sd30426625,
		32'sd34576689, 32'sd38744103, 32'sd42922077, 32'sd47106468, 32'sd51294757,
		32'sd55485411, 32'sd59677501, 32'sd63870462, 32'sd68063952, 32'sd72257762,
		32'sd76451766, 32'sd80645888, 32'sd84840082, 32'sd89034319, 32'sd93228583,
		32'sd97422862, 32'sd101617151, 32'sd105811446, 32'sd110005744, 32'sd114200045,
		32'sd118394347, 32'sd122588650
	};

	localparam logic signed [31:0] TANH_END = 32'sd16777212;

endpackage

// ===== hw/rtl/ats_mul.sv =====
module ats_mul (
	input  logic                                clk,
	input  logic signed [ats_pkg::MUL_AW-1:0]   a,
	input  logic signed [ats_pkg::MUL_BW-1:0]   b,
	output logic signed [ats_pkg::MUL_PW-1:0]   p
);
	import ats_pkg::*;

	// Registered product, ready in the cycle after the operands are presented.
	always_ff @(posedge clk) begin
		p <= MUL_PW'(a) * MUL_PW'(b);
	end

endmodule

// ===== hw/rtl/ats_div.sv =====
module ats_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [32:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	import ats_pkg::*;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_PREP = 4'b0010,
		D_RUN  = 4'b0100,
		D_DONE = 4'b1000
	} div_state_t;

	div_state_t state_q;
	logic [31:0] nm_q, dm_q, rem_q;
	logic [23:0] q_q;
	logic [4:0]  cnt_q;
	logic        neg_q, sat_q;
	logic [32:0] rem2;
	logic [32:0] trial;
	logic signed [31:0] mag;

	assign rem2  = {rem_q, 1'b0};
	assign trial = rem2 - {1'b0, dm_q};

	// Quotient of (num * 2^24) / den, truncated toward zero, clamped in magnitude to one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			nm_q <= '0;
			dm_q <= '0;
			rem_q <= '0;
			q_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						nm_q <= num[31] ? 32'(-num) : 32'(num);
						dm_q <= den[32] ? 32'(-den) : 32'(den);
						neg_q <= num[31] ^ den[32];
						state_q <= D_PREP;
					end
				end
				D_PREP: begin
					sat_q <= (nm_q >= dm_q);
					rem_q <= nm_q;
					q_q <= '0;
					cnt_q <= '0;
					state_q <= (nm_q >= dm_q) ? D_DONE : D_RUN;
				end
				D_RUN: begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						q_q <= {q_q[22:0], 1'b1};
					end else begin
						rem_q <= rem2[31:0];
						q_q <= {q_q[22:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign mag  = sat_q ? ONE_Q24 : signed'({8'd0, q_q});
	assign quo  = neg_q ? -mag : mag;
	assign done = (state_q == D_DONE);

endmodule

// ===== hw/rtl/adaa_tanh_saturator_unit.sv =====
// First-order ADAA tanh saturator with DC blocker and dry/wet mix.
// When the driven step is tiny, a plain tanh lookup gives the result and the
// divider is skipped; otherwise the 24-step serial divider dominates the path.
// One item is processed at a time: the next input beat is taken only once the
// last result has entered the output register. A result still waiting in the
// output register holds the sequencer in its last state.
// Reset (arst_n low, asynchronous) clears all channel history and restores
// drive_gain to unity (4096) and wet_mix to fully wet (32768).
module adaa_tanh_saturator_unit #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  ats_pkg::cfg_reg_t             cfg_index,
	input  logic [ats_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          channel_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          channel_out
);
	import ats_pkg::*;

	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DSH = SAMPLE_BITS - 13;
	localparam int MXW = 56;
	localparam int SH  = 47 - SAMPLE_BITS;
	localparam int DRY_SH = 32 - SAMPLE_BITS;
	localparam logic signed [MXW-1:0] MX_HALF = MXW'(1) <<< (SH - 1);
	localparam logic signed [MXW-1:0] S_MAX = (MXW'(1) <<< (SAMPLE_BITS - 1)) - MXW'(1);
	localparam logic signed [MXW-1:0] S_MIN = -(MXW'(1) <<< (SAMPLE_BITS - 1));
	localparam logic signed [MUL_PW-1:0] BLK_HALF = MUL_PW'(1) <<< 23;
	localparam logic signed [MUL_PW-1:0] I32_MAX = MUL_PW'(32'h7fffffff);
	localparam logic signed [MUL_PW-1:0] I32_MIN = -(MUL_PW'(1) <<< 31);

	// The sequencer walks one item through the shared multiplier, the table
	// interpolation and the serial divider. Every state but idle, the divider
	// wait and the output hand-over moves on unconditionally.
	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_DRV  = 13'b0000000000010,
		ST_XN   = 13'b0000000000100,
		ST_LKA  = 13'b0000000001000,
		ST_LKR  = 13'b0000000010000,
		ST_DIVS = 13'b0000000100000,
		ST_DIV  = 13'b0000001000000,
		ST_BLK  = 13'b0000010000000,
		ST_BLKR = 13'b0000100000000,
		ST_MIXA = 13'b0001000000000,
		ST_MIXB = 13'b0010000000000,
		ST_MIXR = 13'b0100000000000,
		ST_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [15:0] gain_q, wet_mix_q;
	logic [15:0] mix_m;

	logic signed [SAMPLE_BITS-1:0] dry_q;
	logic                          chr_q;
	logic [CW-1:0]                 ch_q;
	logic [CW:0]                   ch_ext;
	logic [CW-1:0]                 ch_sel;

	// Per-channel history: previous driven value and DC blocker memory.
	logic signed [31:0] prev_q [CHANNELS];
	logic signed [31:0] li_q   [CHANNELS];
	logic signed [31:0] lo_q   [CHANNELS];

	logic signed [31:0] xp_q, lk_x_q, lcn_q, diff_q, wet_q, blk_q;
	logic signed [32:0] delta_q;
	logic               lk_step_q;

	// Lookup stage registers.
	logic signed [31:0] base_q, a_q;
	logic               big_q, neg_q, tanh_q;

	logic signed [MXW-1:0]          mix1_q;
	logic signed [SAMPLE_BITS-1:0]  res_q;
	logic signed [SAMPLE_BITS-1:0]  sample_q;
	logic                           chout_q, ov_q;

	// Shared multiplier.
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] mul_p;

	// Divider handshake.
	logic               div_done;
	logic signed [31:0] div_q;

	// Combinational helpers.
	logic signed [MUL_PW-1:0] xn_full;
	logic signed [31:0]       xn;
	logic signed [31:0]       lk_a;
	logic                     lk_big, use_tanh, tiny;
	logic [5:0]               idx;
	logic [LUT_STEP_BITS-1:0] frac;
	logic signed [31:0]       lk_base, lk_next, lk_span;
	logic signed [31:0]       interp, tanh_mag, lk_val;
	logic signed [33:0]       acc;
	logic signed [MUL_PW-1:0] blk_full;
	logic signed [31:0]       blocked;
	logic signed [MXW-1:0]    mix_sum, mix_rnd;
	logic signed [SAMPLE_BITS-1:0] mix_res;

	assign mix_m = (wet_mix_q > MIX_FULL) ? MIX_FULL : wet_mix_q;

	// Out-of-range channel numbers fall onto the last channel.
	assign ch_ext = (CW + 1)'(channel_in);
	assign ch_sel = (ch_ext >= (CW + 1)'(CHANNELS)) ? CW'(CHANNELS - 1) : ch_ext[CW-1:0];

	// Driven value: sample times gain, floored to Q8.24.
	assign xn_full = mul_p >>> DSH;
	assign xn      = 32'(xn_full);

	// Step is tiny when it lies strictly within the 1e-6 window.
	assign tiny = (delta_q > -TINY_Q24) && (delta_q < TINY_Q24);

	// Table address from the magnitude; beyond the table end the asymptote holds.
	assign lk_a     = lk_x_q[31] ? -lk_x_q : lk_x_q;
	assign lk_big   = (lk_a >= (32'sd1 <<< 27));
	assign idx      = {1'b0, lk_a[26:22]};
	assign frac     = lk_a[LUT_STEP_BITS-1:0];
	assign use_tanh = !lk_step_q && tiny;
	assign lk_base  = use_tanh ? TANH_TAB[idx] : LOGCOSH_TAB[idx];
	assign lk_next  = use_tanh ? TANH_TAB[idx + 6'd1] : LOGCOSH_TAB[idx + 6'd1];
	assign lk_span  = lk_next - lk_base;

	// Interpolated value once the span product is back.
	assign interp   = base_q + 32'(mul_p >>> LUT_STEP_BITS);
	assign tanh_mag = big_q ? TANH_END : interp;
	assign lk_val   = tanh_q ? (neg_q ? -tanh_mag : tanh_mag)
	                         : (big_q ? (a_q - LN2_Q24) : interp);

	// DC blocker: 0.997 * (last_out + wet - last_in), rounded half up.
	assign acc      = 34'(lo_q[ch_q]) + 34'(wet_q) - 34'(li_q[ch_q]);
	assign blk_full = (mul_p + BLK_HALF) >>> 24;
	assign blocked  = (blk_full > I32_MAX) ? 32'sh7fffffff :
	                  (blk_full < I32_MIN) ? 32'sh80000000 : 32'(blk_full);

	// Mix: wet share was formed in the previous cycle, dry share arrives now.
	assign mix_sum = mix1_q + (MXW'(mul_p) <<< DRY_SH);
	assign mix_rnd = (mix_sum + MX_HALF) >>> SH;
	assign mix_res = (mix_rnd > S_MAX) ? SAMPLE_BITS'(S_MAX) :
	                 (mix_rnd < S_MIN) ? SAMPLE_BITS'(S_MIN) : SAMPLE_BITS'(mix_rnd);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DRV: begin
				mul_a = MUL_AW'(dry_q);
				mul_b = MUL_BW'(signed'({1'b0, gain_q}));
			end
			ST_LKA: begin
				mul_a = MUL_AW'(lk_span);
				mul_b = MUL_BW'(signed'({1'b0, frac}));
			end
			ST_BLK: begin
				mul_a = MUL_AW'(acc);
				mul_b = BLOCK_COEF_Q24;
			end
			ST_MIXA: begin
				mul_a = MUL_AW'(blk_q);
				mul_b = MUL_BW'(signed'({1'b0, mix_m}));
			end
			ST_MIXB: begin
				mul_a = MUL_AW'(dry_q);
				mul_b = MUL_BW'(signed'({1'b0, MIX_FULL - mix_m}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ats_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ats_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIVS),
		.num    (diff_q),
		.den    (delta_q),
		.done   (div_done),
		.quo    (div_q)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = ov_q;
	assign sample_out  = sample_q;
	assign channel_out = chout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gain_q    <= 16'd4096;
			wet_mix_q <= MIX_FULL;
			ov_q      <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				prev_q[c] <= '0;
				li_q[c]   <= '0;
				lo_q[c]   <= '0;
			end
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_DRIVE_GAIN: gain_q <= cfg_data;
					REG_WET_MIX:    wet_mix_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// A new result takes the output register as soon as it is free.
			if (state_q == ST_OUT && (!ov_q || out_ready)) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DRV;
					end
				end
				ST_DRV: begin
					state_q <= ST_XN;
				end
				ST_XN: begin
					prev_q[ch_q] <= xn;
					state_q <= ST_LKA;
				end
				ST_LKA: begin
					state_q <= ST_LKR;
				end
				ST_LKR: begin
					if (tanh_q) begin
						state_q <= ST_BLK;
					end else if (!lk_step_q) begin
						state_q <= ST_LKA;
					end else begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BLK;
					end
				end
				ST_BLK: begin
					li_q[ch_q] <= wet_q;
					state_q <= ST_BLKR;
				end
				ST_BLKR: begin
					lo_q[ch_q] <= blocked;
					state_q <= ST_MIXA;
				end
				ST_MIXA: begin
					state_q <= ST_MIXB;
				end
				ST_MIXB: begin
					state_q <= ST_MIXR;
				end
				ST_MIXR: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Hand the result over once the output register is free.
					if (!ov_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they carry no control meaning and need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dry_q <= sample_in;
					chr_q <= channel_in;
					ch_q  <= ch_sel;
				end
			end
			ST_XN: begin
				xp_q      <= prev_q[ch_q];
				delta_q   <= 33'(xn) - 33'(prev_q[ch_q]);
				lk_x_q    <= xn;
				lk_step_q <= 1'b0;
			end
			ST_LKA: begin
				base_q <= lk_base;
				a_q    <= lk_a;
				big_q  <= lk_big;
				neg_q  <= lk_x_q[31];
				tanh_q <= use_tanh;
			end
			ST_LKR: begin
				if (tanh_q) begin
					wet_q <= lk_val;
				end else if (!lk_step_q) begin
					lcn_q     <= lk_val;
					lk_step_q <= 1'b1;
					lk_x_q    <= xp_q;
				end else begin
					diff_q <= lcn_q - lk_val;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					wet_q <= div_q;
				end
			end
			ST_BLKR: begin
				blk_q <= blocked;
			end
			ST_MIXB: begin
				mix1_q <= MXW'(mul_p) <<< 7;
			end
			ST_MIXR: begin
				res_q <= mix_res;
			end
			ST_OUT: begin
				// The previous result stays on the outputs until it is taken.
				if (!ov_q || out_ready) begin
					sample_q <= res_q;
					chout_q  <= chr_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/tb_adaa_tanh_saturator_unit.sv =====
`timescale 1ns / 1ps

module tb_adaa_tanh_saturator_unit;
	import ats_pkg::*;

	// Cycles with no beat on either side before the run is declared hung.
	localparam int HANG_LIMIT = 6000;
	// Longer than the worst-case latency, so this covers any item still in flight.
	localparam int SETTLE_CYCLES = 50;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic signed [23:0] sample;
		logic               channel;
	} sat_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	cfg_reg_t           cfg_index = REG_DRIVE_GAIN;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [23:0] sample_in = '0;
	logic               channel_in = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [23:0] sample_out;
	logic               channel_out;

	adaa_tanh_saturator_unit #(
		.CHANNELS(2),
		.SAMPLE_BITS(24)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.channel_in(channel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.channel_out(channel_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Our own copies of the tanh and log-cosh tables, 0.25 steps over [0, 8] in Q.24.
	longint tanh_pts [33] = '{
		0, 4109053, 7753039, 10656031, 12777430, 14231838, 15185868, 15793661,
		16173699, 16408555, 16552641, 16640645, 16694249, 16726845, 16746646,
		16758668, 16765964, 16770390, 16773076, 16774705, 16775693, 16776292,
		16776656, 16776876, 16777010, 16777091, 16777140, 16777170, 16777188,
		16777199, 16777206, 16777210, 16777212
	};
	longint lcosh_pts [33] = '{
		0, 518916, 2015187, 4332986, 7277635, 10665990, 14351905, 18230177,
		22229857, 26305006, 30426625, 34576689, 38744103, 42922077, 47106468,
		51294757, 55485411, 59677501, 63870462, 68063952, 72257762, 76451766,
		80645888, 84840082, 89034319, 93228583, 97422862, 101617151, 105811446,
		110005744, 114200045, 118394347, 122588650
	};

	// Predictor state: settings and per-channel history, mirroring the block.
	logic [15:0]  gain_set = 16'd4096;
	logic [15:0]  mix_set = 16'd32768;
	longint       drv_hist [2] = '{0, 0};
	longint       dcb_in [2] = '{0, 0};
	longint       dcb_out [2] = '{0, 0};
	sat_result_t  pending_q [$];
	int           fails = 0;
	bit           idle_en = 1'b1;
	int           hold_req = 0;
	logic signed [23:0] last_smp [2] = '{0, 0};

	// Linear interpolation into one of the tables, truncating toward minus infinity.
	function automatic longint tab_interp(bit use_lcosh, longint a);
		int     i;
		longint fr, t0, t1;
		i = int'(a >>> 22);
		fr = a & 64'h3F_FFFF;
		t0 = use_lcosh ? lcosh_pts[i] : tanh_pts[i];
		t1 = use_lcosh ? lcosh_pts[i + 1] : tanh_pts[i + 1];
		return t0 + (((t1 - t0) * fr) >>> 22);
	endfunction

	function automatic longint tanh_val(longint x);
		longint a, r;
		a = x < 0 ? -x : x;
		r = (a >= (64'sd32 <<< 22)) ? tanh_pts[32] : tab_interp(1'b0, a);
		return x < 0 ? -r : r;
	endfunction

	// Past the table end log-cosh follows its asymptote |x| - ln2.
	function automatic longint lcosh_val(longint x);
		longint a;
		a = x < 0 ? -x : x;
		if (a >= (64'sd32 <<< 22))
			return a - longint'(LN2_Q24);
		return tab_interp(1'b1, a);
	endfunction

	// Computes the mixed output for one accepted sample and advances the history.
	function automatic logic signed [23:0] saturate_sample(logic signed [23:0] smp, logic ch);
		longint dry, xn, xp, step, wet, diff, acc, blk, m, mixacc, res;
		dry = smp;
		xn = (dry * longint'(gain_set)) >>> 11;
		xp = drv_hist[ch];
		step = xn - xp;
		if (step > -17 && step < 17) begin
			wet = tanh_val(xn);
		end else begin
			diff = lcosh_val(xn) - lcosh_val(xp);
			wet = (diff * 64'sd16777216) / step;
			if (wet > 64'sd16777216)
				wet = 64'sd16777216;
			if (wet < -64'sd16777216)
				wet = -64'sd16777216;
		end
		drv_hist[ch] = xn;

		// DC blocker, rounded half up and held to the signed 32-bit range.
		acc = dcb_out[ch] + wet - dcb_in[ch];
		blk = (acc * 64'sd16726884 + (64'sd1 <<< 23)) >>> 24;
		if (blk > 64'sd2147483647)
			blk = 64'sd2147483647;
		if (blk < -64'sd2147483648)
			blk = -64'sd2147483648;
		dcb_in[ch] = wet;
		dcb_out[ch] = blk;

		// Any mix above full scale acts as fully wet.
		m = (mix_set > 16'd32768) ? 64'sd32768 : longint'(mix_set);
		mixacc = blk * 128 * m + dry * 256 * (64'sd32768 - m);
		res = (mixacc + (64'sd1 <<< 22)) >>> 23;
		if (res > 64'sd8388607)
			res = 64'sd8388607;
		if (res < -64'sd8388608)
			res = -64'sd8388608;
		return res[23:0];
	endfunction

	// Result side: random stalls, plus a long hold-off when a test asks for one.
	int hold_left = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		sat_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result beat: sample_out %0d channel_out %0d",
					sample_out, channel_out);
				fails++;
			end else begin
				want = pending_q.pop_front();
				if (sample_out !== want.sample) begin
					$error("sample_out: expected %0d, actual %0d", want.sample, sample_out);
					fails++;
				end
				if (channel_out !== want.channel) begin
					$error("channel_out: expected %0d, actual %0d", want.channel, channel_out);
					fails++;
				end
			end
		end
	end

	// Hang detection: count cycles in which work is outstanding but no beat moves.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (!in_valid && pending_q.size() == 0)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offers one sample and returns in the time step of the edge that took it,
	// with valid still high; the caller either offers the next beat or lowers it.
	task automatic send_sample(input logic signed [23:0] smp, input logic ch);
		int gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= smp;
		channel_in <= ch;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back('{sample: saturate_sample(smp, ch), channel: ch});
		last_smp[ch] = smp;
	endtask

	// Stops offering and waits until every expected result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Called only while the block is idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_DRIVE_GAIN)
			gain_set = val;
		else
			mix_set = val;
		@(posedge clk);
	endtask

	// Mostly full-range noise, with repeats and tiny steps to hit the plain-tanh
	// fallback, and the two range ends.
	function automatic logic signed [23:0] pick_sample(logic ch);
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return last_smp[ch];
			3: return last_smp[ch] + $signed(24'($urandom_range(0, 6)) - 24'sd3);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_sample(24'sd0, 1'b0);
		send_sample(24'sh7FFFFF, 1'b0);
		send_sample(24'sh800000, 1'b0);
		send_sample(24'sh800000, 1'b1);
		send_sample(24'sh800000, 1'b1);
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(-24'sd1, 1'b0);
		send_sample(24'sd1, 1'b0);
		send_sample(24'sh555555, 1'b1);
		send_sample(24'shAAAAAA, 1'b0);
		drain_results();
		// Maximum drive pushes the driven value past the table end.
		write_reg(REG_DRIVE_GAIN, 16'hFFFF);
		write_reg(REG_WET_MIX, 16'd0);
		send_sample(24'sh7FFFFF, 1'b0);
		send_sample(24'sh800000, 1'b0);
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(24'sh7FFFFF, 1'b1);
		drain_results();
		// Mix above full scale, and zero drive where every step is tiny.
		write_reg(REG_WET_MIX, 16'hFFFF);
		send_sample(24'sh400000, 1'b0);
		send_sample(24'shC00000, 1'b1);
		drain_results();
		write_reg(REG_DRIVE_GAIN, 16'd0);
		write_reg(REG_WET_MIX, 16'd16384);
		send_sample(24'sh7FFFFF, 1'b0);
		send_sample(24'sh800000, 1'b1);
		send_sample(24'sd12345, 1'b0);
		drain_results();
	endtask

	task automatic test_random_phases();
		logic ch;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_DRIVE_GAIN, (ph == 0) ? 16'd4096 : 16'($urandom));
			write_reg(REG_WET_MIX, (ph == 1) ? 16'd32768 : 16'($urandom_range(0, 40000)));
			idle_en = (ph != 3);
			for (int n = 0; n < 250; n++) begin
				ch = $urandom_range(0, 1);
				send_sample(pick_sample(ch), ch);
			end
			drain_results();
		end
		idle_en = 1'b1;
	endtask

	// The result side holds off while samples keep coming, so the block backs up.
	task automatic test_backpressure();
		logic ch;
		hold_req = LONG_HOLD;
		for (int n = 0; n < 40; n++) begin
			ch = $urandom_range(0, 1);
			send_sample(pick_sample(ch), ch);
		end
		drain_results();
	endtask

	// The sender stops until everything is out, then picks up where it left off.
	task automatic test_sender_pause();
		logic ch;
		for (int r = 0; r < 2; r++) begin
			for (int n = 0; n < 30; n++) begin
				ch = $urandom_range(0, 1);
				send_sample(pick_sample(ch), ch);
			end
			in_valid <= 1'b0;
			do @(posedge clk); while (pending_q.size() != 0);
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		logic ch;
		idle_en = 1'b0;
		write_reg(REG_DRIVE_GAIN, 16'd8192);
		write_reg(REG_WET_MIX, 16'd24576);
		for (int n = 0; n < 250; n++) begin
			ch = $urandom_range(0, 1);
			send_sample(pick_sample(ch), ch);
		end
		drain_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		test_full_rate();
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
